### rtl/core/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int CAPACITY    = 16;
    localparam int KEY_BITS    = 16;
    localparam int COUNT_BITS  = 16;
    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 3;
    localparam int IDX_BITS    = $clog2(CAPACITY);
    localparam int TOTAL_BITS  = $clog2(CAPACITY + 1);

    localparam int S_DATA_BITS = ((OP_BITS + KEY_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS =
        ((STATUS_BITS + KEY_BITS + COUNT_BITS + TOTAL_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_FULL = TOTAL_BITS'(CAPACITY);

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_INSERT       = 3'd0;
    localparam logic [OP_BITS-1:0] OP_LIKE         = 3'd1;
    localparam logic [OP_BITS-1:0] OP_UNLIKE       = 3'd2;
    localparam logic [OP_BITS-1:0] OP_REMOVE_FIRST = 3'd3;
    localparam logic [OP_BITS-1:0] OP_REMOVE_LAST  = 3'd4;
    localparam logic [OP_BITS-1:0] OP_QUERY_MAX    = 3'd5;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] STS_NOT_FOUND = 3'd1;
    localparam logic [STATUS_BITS-1:0] STS_EMPTY     = 3'd2;
    localparam logic [STATUS_BITS-1:0] STS_FULL      = 3'd3;
    localparam logic [STATUS_BITS-1:0] STS_SATURATED = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_QUERY,
        S_EXEC,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SO_NONE,
        SO_INSERT,
        SO_POP_FRONT,
        SO_SET_COUNT
    } store_op_t;

    typedef struct packed {
        store_op_t              op;
        logic [IDX_BITS-1:0]    pos;
        logic [KEY_BITS-1:0]    key;
        logic [COUNT_BITS-1:0]  count;
    } store_cmd_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [KEY_BITS-1:0]    key;
        logic [COUNT_BITS-1:0]  count;
        logic [TOTAL_BITS-1:0]  total;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/skt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_store
    import skt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire store_cmd_t            cmd,
    input  wire logic [IDX_BITS-1:0]   rd_addr,
    output logic      [KEY_BITS-1:0]   rd_key,
    output logic      [COUNT_BITS-1:0] rd_count
);

    logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
    logic [COUNT_BITS-1:0] count_mem [CAPACITY];

    assign rd_key   = key_mem[rd_addr];
    assign rd_count = count_mem[rd_addr];

    // Each entry only ever takes data from itself, a neighbor or the command.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
        logic [IDX_BITS-1:0] here;
        assign here = IDX_BITS'(i);

        always_ff @(posedge aclk) begin
            unique case (cmd.op)
                SO_INSERT: begin
                    if (here == cmd.pos) begin
                        key_mem[i]   <= cmd.key;
                        count_mem[i] <= cmd.count;
                    end else if (here > cmd.pos) begin
                        key_mem[i]   <= key_mem[(i > 0) ? i - 1 : 0];
                        count_mem[i] <= count_mem[(i > 0) ? i - 1 : 0];
                    end
                end
                SO_POP_FRONT: begin
                    if (i < CAPACITY - 1) begin
                        key_mem[i]   <= key_mem[(i < CAPACITY - 1) ? i + 1 : i];
                        count_mem[i] <= count_mem[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
                SO_SET_COUNT: begin
                    if (here == cmd.pos) begin
                        count_mem[i] <= cmd.count;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/skt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_BITS-1:0]    in_op,
    input  wire logic [KEY_BITS-1:0]   in_key,
    input  wire logic [COUNT_BITS-1:0] in_count,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output result_t                    res,
    output store_cmd_t                 cmd,
    output logic      [IDX_BITS-1:0]   rd_addr,
    input  wire logic [KEY_BITS-1:0]   rd_key,
    input  wire logic [COUNT_BITS-1:0] rd_count
);

    state_t                  state_reg,      state_next;
    logic [TOTAL_BITS-1:0]   total_reg,      total_next;
    logic [TOTAL_BITS-1:0]   idx_reg,        idx_next;
    logic [OP_BITS-1:0]      op_reg,         op_next;
    logic [KEY_BITS-1:0]     key_reg,        key_next;
    logic [COUNT_BITS-1:0]   start_reg,      start_next;
    logic [KEY_BITS-1:0]     best_key_reg,   best_key_next;
    logic [COUNT_BITS-1:0]   best_count_reg, best_count_next;
    logic [STATUS_BITS-1:0]  status_reg,     status_next;
    logic [KEY_BITS-1:0]     rkey_reg,       rkey_next;
    logic [COUNT_BITS-1:0]   rcount_reg,     rcount_next;

    logic                    in_range;
    logic                    scan_stop;
    logic                    is_like;
    logic [COUNT_BITS-1:0]   count_step;

    assign in_range = idx_reg < total_reg;
    assign rd_addr  = idx_reg[IDX_BITS-1:0];
    assign is_like  = op_reg == OP_LIKE;

    // Shared compare: insert stops at the first key not below the new one,
    // like and unlike stop at the first equal key.
    assign scan_stop = (op_reg == OP_INSERT) ? !(rd_key < key_reg) : (rd_key == key_reg);

    // Shared counter unit: one adder for both directions.
    assign count_step = rd_count + (is_like ? COUNT_BITS'(1) : COUNT_MAX);

    assign res.status = status_reg;
    assign res.key    = rkey_reg;
    assign res.count  = rcount_reg;
    assign res.total  = total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        start_reg      <= start_next;
        best_key_reg   <= best_key_next;
        best_count_reg <= best_count_next;
        status_reg     <= status_next;
        rkey_reg       <= rkey_next;
        rcount_reg     <= rcount_next;
    end

    always_comb begin
        state_next      = state_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        start_next      = start_reg;
        best_key_next   = best_key_reg;
        best_count_next = best_count_reg;
        status_next     = status_reg;
        rkey_next       = rkey_reg;
        rcount_next     = rcount_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        cmd.op          = SO_NONE;
        cmd.pos         = idx_reg[IDX_BITS-1:0];
        cmd.key         = key_reg;
        cmd.count       = start_reg;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_op;
                    key_next    = in_key;
                    start_next  = in_count;
                    idx_next    = '0;
                    status_next = STS_OK;
                    rkey_next   = '0;
                    rcount_next = '0;
                    unique case (in_op) inside
                        OP_INSERT: begin
                            if (total_reg == TOTAL_FULL) begin
                                status_next = STS_FULL;
                                rkey_next   = in_key;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_LIKE, OP_UNLIKE: begin
                            state_next = S_SCAN;
                        end
                        OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_QUERY_MAX: begin
                            if (total_reg == '0) begin
                                status_next = STS_EMPTY;
                                state_next  = S_DONE;
                            end else if (in_op == OP_QUERY_MAX) begin
                                state_next = S_QUERY;
                            end else begin
                                if (in_op == OP_REMOVE_LAST) begin
                                    idx_next = total_reg - TOTAL_BITS'(1);
                                end
                                state_next = S_EXEC;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (in_range && !scan_stop) begin
                    idx_next = idx_reg + TOTAL_BITS'(1);
                end else begin
                    state_next = S_DONE;
                    if (op_reg == OP_INSERT) begin
                        cmd.op      = SO_INSERT;
                        total_next  = total_reg + TOTAL_BITS'(1);
                        status_next = STS_OK;
                        rkey_next   = key_reg;
                        rcount_next = start_reg;
                    end else if (!in_range) begin
                        status_next = STS_NOT_FOUND;
                        rkey_next   = key_reg;
                        rcount_next = '0;
                    end else if (is_like && rd_count == COUNT_MAX) begin
                        status_next = STS_SATURATED;
                        rkey_next   = key_reg;
                        rcount_next = COUNT_MAX;
                    end else begin
                        cmd.op      = SO_SET_COUNT;
                        cmd.count   = (!is_like && rd_count == '0) ? '0 : count_step;
                        status_next = STS_OK;
                        rkey_next   = rd_key;
                        rcount_next = cmd.count;
                    end
                end
            end

            S_QUERY: begin
                if (in_range) begin
                    if (idx_reg == '0 || rd_count > best_count_reg) begin
                        best_key_next   = rd_key;
                        best_count_next = rd_count;
                    end
                    idx_next = idx_reg + TOTAL_BITS'(1);
                end else begin
                    status_next = STS_OK;
                    rkey_next   = best_key_reg;
                    rcount_next = best_count_reg;
                    state_next  = S_DONE;
                end
            end

            S_EXEC: begin
                if (op_reg == OP_REMOVE_FIRST) begin
                    cmd.op = SO_POP_FRONT;
                end
                status_next = STS_OK;
                rkey_next   = rd_key;
                rcount_next = rd_count;
                total_next  = total_reg - TOTAL_BITS'(1);
                state_next  = S_DONE;
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/sorted_key_table_with_counters.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Bits  Beat contents
// s_axis    in   40    operation, entry_key, start_count
// m_axis    out  40    status, result_key, result_count, entry_total
//
// Insert, like and unlike scan the table from the front, walking one entry
// per cycle through one compare unit; query most liked walks every entry;
// removes use one execute state; a full-table insert, an empty-table remove
// or query and an unused code skip to the result. Synchronous reset empties.
// A result waits in the output register while the next beat is taken; while
// that register is held by m_tready low, the next result keeps s_tready low.

module sorted_key_table_with_counters
    import skt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [2:0] operation, [18:3] entry_key, [34:19] start_count, [39:35] zero
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [2:0] status, [18:3] result_key, [34:19] result_count, [39:35] entry_total
    output logic      [M_DATA_BITS-1:0] m_tdata
);

    store_cmd_t              cmd;
    result_t                 res;
    logic                    res_valid;
    logic                    res_ready;
    logic [IDX_BITS-1:0]     rd_addr;
    logic [KEY_BITS-1:0]     rd_key;
    logic [COUNT_BITS-1:0]   rd_count;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_data_reg,  out_data_next;

    skt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[OP_BITS-1:0]),
        .in_key    (s_tdata[OP_BITS +: KEY_BITS]),
        .in_count  (s_tdata[OP_BITS + KEY_BITS +: COUNT_BITS]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_count  (rd_count)
    );

    skt_store u_store (
        .aclk     (aclk),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_count (rd_count)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_BITS'({out_data_reg.total, out_data_reg.count,
                                    out_data_reg.key, out_data_reg.status});

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res.total <= TOTAL_FULL)
        else $error("entry count exceeds capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again before the previous one finished");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res.status == STS_FULL) |-> res.total == TOTAL_FULL)
        else $error("full status reported on a table with room");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res.status == STS_EMPTY) |-> res.total == '0)
        else $error("empty status reported on a table holding entries");

endmodule

`default_nettype wire

### test/tb_sorted_key_table_with_counters.sv
`timescale 1ns / 1ps

module tb_sorted_key_table_with_counters;
    import skt_pkg::*;

    // Codes six and seven are not assigned to any operation.
    localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;
    localparam int ROWS         = 23;
    localparam int CHUNKS       = 6;
    localparam int CHUNK_BEATS  = 100;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
        logic [4:0]            reps;
        logic                  preset;
        result_t               want;
    } stim_row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [2:0] operation, [18:3] entry_key, [34:19] start_count, [39:35] zero
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [2:0] status, [18:3] result_key, [34:19] result_count, [39:35] entry_total
    logic [M_DATA_BITS-1:0] m_tdata;

    // Shadow copy of the table, updated in acceptance order.
    logic [KEY_BITS-1:0]    tbl_key [CAPACITY];
    logic [COUNT_BITS-1:0]  tbl_cnt [CAPACITY];
    int                     tbl_total = 0;

    result_t                pending_replies [$];
    stim_row_t              dir_rows [ROWS];
    int                     err_count  = 0;
    bit                     quiet      = 1'b0;
    int                     stall_left = 0;

    sorted_key_table_with_counters uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic result_t table_update(logic [OP_BITS-1:0] op,
                                             logic [KEY_BITS-1:0] key,
                                             logic [COUNT_BITS-1:0] count);
        result_t r;
        int      pos;
        int      i;
        r        = '0;
        r.status = STS_OK;
        pos      = 0;
        case (op)
            OP_INSERT: begin
                r.key = key;
                if (tbl_total >= CAPACITY) begin
                    r.status = STS_FULL;
                end else begin
                    // The new entry goes ahead of any equal keys.
                    while (pos < tbl_total && tbl_key[pos] < key) pos++;
                    for (i = tbl_total; i > pos; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_cnt[i] = tbl_cnt[i-1];
                    end
                    tbl_key[pos] = key;
                    tbl_cnt[pos] = count;
                    tbl_total++;
                    r.count = count;
                end
            end
            OP_LIKE, OP_UNLIKE: begin
                r.key = key;
                while (pos < tbl_total && tbl_key[pos] != key) pos++;
                if (pos == tbl_total) begin
                    r.status = STS_NOT_FOUND;
                end else if (op == OP_LIKE && tbl_cnt[pos] == COUNT_MAX) begin
                    r.status = STS_SATURATED;
                    r.count  = COUNT_MAX;
                end else begin
                    if (op == OP_LIKE) begin
                        tbl_cnt[pos]++;
                    end else if (tbl_cnt[pos] != '0) begin
                        tbl_cnt[pos]--;
                    end
                    r.count = tbl_cnt[pos];
                end
            end
            OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_QUERY_MAX: begin
                if (tbl_total == 0) begin
                    r.status = STS_EMPTY;
                end else if (op == OP_REMOVE_FIRST) begin
                    r.key   = tbl_key[0];
                    r.count = tbl_cnt[0];
                    for (i = 1; i < tbl_total; i++) begin
                        tbl_key[i-1] = tbl_key[i];
                        tbl_cnt[i-1] = tbl_cnt[i];
                    end
                    tbl_total--;
                end else if (op == OP_REMOVE_LAST) begin
                    tbl_total--;
                    r.key   = tbl_key[tbl_total];
                    r.count = tbl_cnt[tbl_total];
                end else begin
                    // Strictly greater, so the first of equal maxima wins.
                    for (i = 1; i < tbl_total; i++) begin
                        if (tbl_cnt[i] > tbl_cnt[pos]) pos = i;
                    end
                    r.key   = tbl_key[pos];
                    r.count = tbl_cnt[pos];
                end
            end
            default: ;
        endcase
        r.total = TOTAL_BITS'(tbl_total);
        return r;
    endfunction

    task automatic send_beat(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] key,
                             logic [COUNT_BITS-1:0] count, logic preset,
                             result_t want);
        result_t predicted;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_BITS'({count, key, op});
        do @(posedge aclk); while (!s_tready);
        predicted = table_update(op, key, count);
        pending_replies.push_back(preset ? want : predicted);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : reply_check
        result_t want;
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end

        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result beat with nothing outstanding: %h", m_tdata);
                err_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[2:0] != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                    err_count++;
                end
                if (m_tdata[18:3] != want.key) begin
                    $error("result_key: expected %h, got %h", want.key, m_tdata[18:3]);
                    err_count++;
                end
                if (m_tdata[34:19] != want.count) begin
                    $error("result_count: expected %h, got %h", want.count, m_tdata[34:19]);
                    err_count++;
                end
                if (m_tdata[39:35] != want.total) begin
                    $error("entry_total: expected %0d, got %0d", want.total, m_tdata[39:35]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int                    row;
        int                    rep;
        int                    chunk;
        int                    n;
        int                    pick;
        int                    ins_pct;
        logic [OP_BITS-1:0]    op;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;

        dir_rows = '{
            '{OP_REMOVE_FIRST, 16'h0000, 16'h0000, 5'd1,  1'b1,
              '{STS_EMPTY, 16'h0000, 16'h0000, 5'd0}},
            '{OP_REMOVE_LAST,  16'h0000, 16'h0000, 5'd1,  1'b1,
              '{STS_EMPTY, 16'h0000, 16'h0000, 5'd0}},
            '{OP_QUERY_MAX,    16'h0000, 16'h0000, 5'd1,  1'b1,
              '{STS_EMPTY, 16'h0000, 16'h0000, 5'd0}},
            '{OP_LIKE,         16'h1234, 16'h0000, 5'd1,  1'b1,
              '{STS_NOT_FOUND, 16'h1234, 16'h0000, 5'd0}},
            '{OP_UNLIKE,       16'hFFFF, 16'h0000, 5'd1,  1'b1,
              '{STS_NOT_FOUND, 16'hFFFF, 16'h0000, 5'd0}},
            '{OP_SPARE_6,      16'h0000, 16'h0000, 5'd1,  1'b1,
              '{STS_OK, 16'h0000, 16'h0000, 5'd0}},
            '{OP_SPARE_7,      16'hFFFF, 16'hFFFF, 5'd1,  1'b1,
              '{STS_OK, 16'h0000, 16'h0000, 5'd0}},
            '{OP_INSERT,       16'hFFFF, 16'hFFFF, 5'd1,  1'b1,
              '{STS_OK, 16'hFFFF, 16'hFFFF, 5'd1}},
            '{OP_INSERT,       16'h0000, 16'h0000, 5'd1,  1'b1,
              '{STS_OK, 16'h0000, 16'h0000, 5'd2}},
            '{OP_LIKE,         16'hFFFF, 16'h0000, 5'd1,  1'b1,
              '{STS_SATURATED, 16'hFFFF, 16'hFFFF, 5'd2}},
            '{OP_UNLIKE,       16'h0000, 16'h0000, 5'd1,  1'b1,
              '{STS_OK, 16'h0000, 16'h0000, 5'd2}},
            '{OP_INSERT,       16'h8000, 16'h0005, 5'd1,  1'b0, '0},
            '{OP_INSERT,       16'h8000, 16'h0009, 5'd1,  1'b0, '0},
            '{OP_LIKE,         16'h8000, 16'h0000, 5'd1,  1'b0, '0},
            '{OP_UNLIKE,       16'h8000, 16'h0000, 5'd1,  1'b0, '0},
            '{OP_INSERT,       16'h0001, 16'hFFFE, 5'd1,  1'b0, '0},
            '{OP_LIKE,         16'h0001, 16'h0000, 5'd2,  1'b0, '0},
            '{OP_QUERY_MAX,    16'h0000, 16'h0000, 5'd1,  1'b0, '0},
            '{OP_REMOVE_LAST,  16'h0000, 16'h0000, 5'd1,  1'b0, '0},
            '{OP_REMOVE_FIRST, 16'h0000, 16'h0000, 5'd1,  1'b0, '0},
            '{OP_INSERT,       16'h4000, 16'hAAAA, 5'd13, 1'b0, '0},
            '{OP_INSERT,       16'h5555, 16'h0001, 5'd1,  1'b1,
              '{STS_FULL, 16'h5555, 16'h0000, 5'd16}},
            '{OP_QUERY_MAX,    16'h0000, 16'h0000, 5'd1,  1'b0, '0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < ROWS; row++) begin
            for (rep = 0; rep < dir_rows[row].reps; rep++) begin
                send_beat(dir_rows[row].op, KEY_BITS'(dir_rows[row].key + rep),
                          dir_rows[row].count, dir_rows[row].preset, dir_rows[row].want);
            end
        end
        drain_replies();

        // Chunks alternate between filling, churning and draining the table.
        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk % 3)
                0:       ins_pct = 50;
                1:       ins_pct = 30;
                default: ins_pct = 12;
            endcase
            if (chunk == CHUNKS - 1) quiet = 1'b1;
            for (n = 0; n < CHUNK_BEATS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < ins_pct)           op = OP_INSERT;
                else if (pick < ins_pct + 20) op = OP_LIKE;
                else if (pick < ins_pct + 32) op = OP_UNLIKE;
                else if (pick < ins_pct + 42) op = OP_QUERY_MAX;
                else if (pick < ins_pct + 44) op = OP_SPARE_6;
                else if (pick < ins_pct + 45) op = OP_SPARE_7;
                else if (pick[0])             op = OP_REMOVE_FIRST;
                else                          op = OP_REMOVE_LAST;

                // Lookups mostly hit a live key; inserts often repeat one.
                if ((op == OP_LIKE || op == OP_UNLIKE) && tbl_total > 0 &&
                    $urandom_range(0, 3) != 0) begin
                    key = tbl_key[$urandom_range(0, tbl_total - 1)];
                end else if (op == OP_INSERT && $urandom_range(0, 4) < 2) begin
                    key = KEY_BITS'($urandom_range(0, 15) * 'h1111);
                end else begin
                    key = KEY_BITS'($urandom());
                end

                case ($urandom_range(0, 4))
                    0:       count = COUNT_MAX - COUNT_BITS'($urandom_range(0, 2));
                    1:       count = COUNT_BITS'($urandom_range(0, 2));
                    default: count = COUNT_BITS'($urandom());
                endcase

                send_beat(op, key, count, 1'b0, '0);
            end
            if (chunk == 2) drain_replies();
        end

        drain_replies();
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/skt_pkg.sv
rtl/core/skt_store.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table_with_counters.sv
test/tb_sorted_key_table_with_counters.sv
